[hw/rtl/psid_pkg.sv]
`default_nettype none

package psid_pkg;

  // Action classes
  localparam logic [3:0] ACT_ILLEGAL    = 4'd0;
  localparam logic [3:0] ACT_ECALL      = 4'd1;
  localparam logic [3:0] ACT_EBREAK     = 4'd2;
  localparam logic [3:0] ACT_SRET       = 4'd3;
  localparam logic [3:0] ACT_MRET       = 4'd4;
  localparam logic [3:0] ACT_WFI        = 4'd5;
  localparam logic [3:0] ACT_YIELD      = 4'd6;
  localparam logic [3:0] ACT_FLUSH_PAGE = 4'd7;
  localparam logic [3:0] ACT_FLUSH_ALL  = 4'd8;
  localparam logic [3:0] ACT_CSR        = 4'd9;
  localparam logic [3:0] ACT_NOP        = 4'd10;

  // Exact instruction words and match patterns
  localparam logic [31:0] W_ECALL    = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK   = 32'h0010_0073;
  localparam logic [31:0] W_SRET     = 32'h1020_0073;
  localparam logic [31:0] W_MRET     = 32'h3020_0073;
  localparam logic [31:0] W_WFI      = 32'h1050_0073;
  localparam logic [31:0] W_WRS_NTO  = 32'h00D0_0073;
  localparam logic [31:0] W_WRS_STO  = 32'h01D0_0073;
  localparam logic [31:0] FENCE_MASK = 32'hFE00_7FFF;
  localparam logic [31:0] FENCE_VMA  = 32'h1200_0073;
  localparam logic [31:0] MOP_MASK   = 32'hB000_0000;
  localparam logic [31:0] MOP_MATCH  = 32'h8000_0000;

  // funct3 codes that are not CSR forms
  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_MOP  = 3'd4;

  // Privilege codes
  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_M = 2'd3;

  // mstatus bit positions
  localparam int B_SIE  = 1;
  localparam int B_MIE  = 3;
  localparam int B_SPIE = 5;
  localparam int B_MPIE = 7;
  localparam int B_SPP  = 8;
  localparam int B_MPP  = 11;
  localparam int B_MPRV = 17;
  localparam int B_TVM  = 20;
  localparam int B_TW   = 21;
  localparam int B_TSR  = 22;

  typedef struct packed {
    logic [31:0] insn;
    logic [1:0]  cur_priv;
    logic [63:0] status;
    logic [63:0] sepc;
    logic [63:0] mepc;
    logic [63:0] rs1_value;
  } request_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  trap_cause;
    logic [63:0] new_status;
    logic [1:0]  new_priv;
    logic [63:0] new_pc;
    logic [11:0] csr_address;
    logic [1:0]  csr_kind;
    logic        csr_write;
    logic [63:0] csr_source;
    logic [4:0]  dest_reg;
    logic [63:0] flush_address;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/privileged_system_insn_decoder_top.sv]
`default_nettype none

// Decoder for one RISC-V SYSTEM-opcode instruction per cycle. busy is always
// low, so an item is taken at every edge where start is high. The item lands
// in an input register, is decoded by one level of logic, and its result is
// registered at the next edge; it then sits on result, marked by done, for
// exactly one cycle. The receiver cannot stall, and one result follows every
// item in order. Sustained rate is one item per clock, set by the two-register
// pipeline with no shared unit. Privilege gates (TSR, TW, TVM) turn a failing
// instruction into the illegal action; new_pc is the raw sepc or mepc.
module privileged_system_insn_decoder_top
  import psid_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  request_t req_q;
  logic     req_valid;
  result_t  result_next;

  assign busy = 1'b0;

  // Hold the accepted item and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
    if (start && !busy) begin
      req_q <= request;
    end
  end

  // Decode the held item
  always_comb begin
    logic [2:0]  f3;
    logic [4:0]  rs1f;
    logic [1:0]  priv;
    logic [63:0] st;
    logic [63:0] s;
    logic        priv_s;
    logic        ok_tsr;
    logic        ok_tw;
    logic        ok_tvm;
    logic        matched;
    logic [1:0]  f3lo;

    f3     = req_q.insn[14:12];
    rs1f   = req_q.insn[19:15];
    priv   = req_q.cur_priv;
    st     = req_q.status;
    f3lo   = f3[1:0];
    priv_s = (priv != PRIV_U);
    ok_tsr = (priv_s && !st[B_TSR]) || (priv == PRIV_M);
    ok_tw  = (priv_s && !st[B_TW])  || (priv == PRIV_M);
    ok_tvm = (priv_s && !st[B_TVM]) || (priv == PRIV_M);
    s      = st;
    matched = 1'b0;

    result_next               = '0;
    result_next.action        = ACT_ILLEGAL;
    result_next.new_status    = st;
    result_next.new_priv      = priv;

    // Exact-match forms
    if (req_q.insn == W_ECALL) begin
      result_next.action     = ACT_ECALL;
      result_next.trap_cause = {2'b10, priv};
      matched = 1'b1;
    end else if (req_q.insn == W_EBREAK) begin
      result_next.action = ACT_EBREAK;
      matched = 1'b1;
    end else if (req_q.insn == W_SRET) begin
      if (ok_tsr) begin
        s[B_SPP]  = 1'b0;
        s[B_SIE]  = st[B_SPIE];
        s[B_SPIE] = 1'b1;
        s[B_MPRV] = 1'b0;
        result_next.new_priv   = {1'b0, st[B_SPP]};
        result_next.new_status = s;
        result_next.new_pc     = req_q.sepc;
        result_next.action     = ACT_SRET;
        matched = 1'b1;
      end
    end else if (req_q.insn == W_MRET) begin
      if (priv == PRIV_M) begin
        if (st[B_MPP+1:B_MPP] != PRIV_M) begin
          s[B_MPRV] = 1'b0;
        end
        s[B_MPP+1:B_MPP] = 2'b00;
        s[B_MIE]  = st[B_MPIE];
        s[B_MPIE] = 1'b1;
        result_next.new_priv   = st[B_MPP+1:B_MPP];
        result_next.new_status = s;
        result_next.new_pc     = req_q.mepc;
        result_next.action     = ACT_MRET;
        matched = 1'b1;
      end
    end else if (req_q.insn == W_WFI) begin
      if (ok_tw) begin
        result_next.action = ACT_WFI;
        matched = 1'b1;
      end
    end else if (req_q.insn == W_WRS_NTO || req_q.insn == W_WRS_STO) begin
      result_next.action = ACT_YIELD;
      matched = 1'b1;
    end

    // Pattern forms by funct3
    if (!matched) begin
      case (f3)
        F3_PRIV: begin
          if ((req_q.insn & FENCE_MASK) == FENCE_VMA && ok_tvm) begin
            if (rs1f != 5'd0) begin
              result_next.action        = ACT_FLUSH_PAGE;
              result_next.flush_address = req_q.rs1_value;
            end else begin
              result_next.action = ACT_FLUSH_ALL;
            end
          end
        end
        F3_MOP: begin
          if ((req_q.insn & MOP_MASK) == MOP_MATCH) begin
            result_next.action = ACT_NOP;
          end
        end
        default: begin
          result_next.action      = ACT_CSR;
          result_next.csr_address = req_q.insn[31:20];
          result_next.dest_reg    = req_q.insn[11:7];
          result_next.csr_kind    = f3lo - 2'd1;
          result_next.csr_write   = (f3lo == 2'd1) || (rs1f != 5'd0);
          result_next.csr_source  = f3[2] ? {59'd0, rs1f} : req_q.rs1_value;
        end
      endcase
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
    result <= result_next;
  end

  // Every result traces back to an item accepted through the input and result registers
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result without an accepted item");

  // CSR request fields stay quiet outside the CSR action
  a_csr_quiet: assert property (@(posedge clk) disable iff (rst)
    done && result.action != ACT_CSR |->
      !result.csr_write && result.csr_address == 12'd0 && result.dest_reg == 5'd0)
    else $error("csr fields set on a non-csr action");

  // Jump target only for the return actions
  a_pc_quiet: assert property (@(posedge clk) disable iff (rst)
    done && result.action != ACT_SRET && result.action != ACT_MRET |->
      result.new_pc == 64'd0)
    else $error("new_pc set without xret");

  // Ecall cause lies in the environment-call range
  a_ecall_cause: assert property (@(posedge clk) disable iff (rst)
    done && result.action == ACT_ECALL |-> result.trap_cause[3:2] == 2'b10)
    else $error("bad ecall cause");

  // Privilege changes only on a return
  a_priv_hold: assert property (@(posedge clk) disable iff (rst)
    done && result.action != ACT_SRET && result.action != ACT_MRET |->
      result.new_priv == $past(req_q.cur_priv))
    else $error("privilege changed without xret");

endmodule

`default_nettype wire

[bench/tb_privileged_system_insn_decoder_top.sv]
`timescale 1ns / 100ps

module tb_privileged_system_insn_decoder_top
  import psid_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam logic [3:0] ECALL_CAUSE_BASE = 4'd8;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  localparam logic [2:0] F3_CSRRW = 3'd1;
  localparam logic [2:0] F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_CSRRC = 3'd3;
  localparam logic [2:0] F3_CSRRWI = 3'd5;
  localparam logic [2:0] F3_CSRRSI = 3'd6;
  localparam logic [2:0] F3_CSRRCI = 3'd7;
  localparam logic [6:0] F7_SFENCE = 7'b0001001;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  request_t request;
  logic done;
  result_t result;

  // Expected decode results, oldest first, with the decode rules of the block
  class decode_scoreboard;
    result_t expected_q[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    function bit gate_open(logic [1:0] priv, logic [63:0] st, int pos);
      return (priv >= PRIV_S && !st[pos]) || priv == PRIV_M;
    endfunction

    function result_t decode(request_t r);
      result_t o;
      logic [63:0] s;
      logic [2:0] f3;
      logic [4:0] rs1f;
      bit hit;
      o = '0;
      o.action = ACT_ILLEGAL;
      o.new_status = r.status;
      o.new_priv = r.cur_priv;
      s = r.status;
      f3 = r.insn[14:12];
      rs1f = r.insn[19:15];
      hit = 1'b0;
      // exact-match words first
      case (r.insn)
        W_ECALL: begin
          o.action = ACT_ECALL;
          o.trap_cause = ECALL_CAUSE_BASE + {2'b00, r.cur_priv};
          hit = 1'b1;
        end
        W_EBREAK: begin
          o.action = ACT_EBREAK;
          hit = 1'b1;
        end
        W_SRET: begin
          if (gate_open(r.cur_priv, r.status, B_TSR)) begin
            o.new_priv = {1'b0, s[B_SPP]};
            s[B_SPP] = 1'b0;
            s[B_SIE] = s[B_SPIE];
            s[B_SPIE] = 1'b1;
            s[B_MPRV] = 1'b0;
            o.new_status = s;
            o.new_pc = r.sepc;
            o.action = ACT_SRET;
            hit = 1'b1;
          end
        end
        W_MRET: begin
          if (r.cur_priv == PRIV_M) begin
            o.new_priv = s[B_MPP+1 -: 2];
            if (o.new_priv != PRIV_M) s[B_MPRV] = 1'b0;
            s[B_MPP+1 -: 2] = 2'b00;
            s[B_MIE] = s[B_MPIE];
            s[B_MPIE] = 1'b1;
            o.new_status = s;
            o.new_pc = r.mepc;
            o.action = ACT_MRET;
            hit = 1'b1;
          end
        end
        W_WFI: begin
          if (gate_open(r.cur_priv, r.status, B_TW)) begin
            o.action = ACT_WFI;
            hit = 1'b1;
          end
        end
        W_WRS_NTO, W_WRS_STO: begin
          o.action = ACT_YIELD;
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
      // then by funct3: fences, may-be-ops and the CSR forms
      if (!hit) begin
        case (f3)
          F3_PRIV: begin
            if ((r.insn & FENCE_MASK) == FENCE_VMA &&
                gate_open(r.cur_priv, r.status, B_TVM)) begin
              if (rs1f != 5'd0) begin
                o.action = ACT_FLUSH_PAGE;
                o.flush_address = r.rs1_value;
              end else begin
                o.action = ACT_FLUSH_ALL;
              end
            end
          end
          F3_MOP: begin
            if ((r.insn & MOP_MASK) == MOP_MATCH) o.action = ACT_NOP;
          end
          default: begin
            o.action = ACT_CSR;
            o.csr_address = r.insn[31:20];
            o.dest_reg = r.insn[11:7];
            o.csr_kind = f3[1:0] - 2'd1;
            o.csr_write = (f3[1:0] == 2'd1) || (rs1f != 5'd0);
            o.csr_source = f3[2] ? {59'd0, rs1f} : r.rs1_value;
          end
        endcase
      end
      return o;
    endfunction

    function void note_item(request_t r);
      expected_q.push_back(decode(r));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = expected_q.pop_front();
        compare_field("action", 64'(got.action), 64'(want.action));
        compare_field("trap_cause", 64'(got.trap_cause), 64'(want.trap_cause));
        compare_field("new_status", got.new_status, want.new_status);
        compare_field("new_priv", 64'(got.new_priv), 64'(want.new_priv));
        compare_field("new_pc", got.new_pc, want.new_pc);
        compare_field("csr_address", 64'(got.csr_address), 64'(want.csr_address));
        compare_field("csr_kind", 64'(got.csr_kind), 64'(want.csr_kind));
        compare_field("csr_write", 64'(got.csr_write), 64'(want.csr_write));
        compare_field("csr_source", got.csr_source, want.csr_source);
        compare_field("dest_reg", 64'(got.dest_reg), 64'(want.dest_reg));
        compare_field("flush_address", got.flush_address, want.flush_address);
      end
    endtask
  endclass

  decode_scoreboard sb;
  int unsigned burst_left;

  privileged_system_insn_decoder_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic request_t make_item(logic [31:0] insn, logic [1:0] priv, logic [63:0] st);
    request_t r;
    r.insn = insn;
    r.cur_priv = priv;
    r.status = st;
    r.sepc = rand64();
    r.mepc = rand64();
    r.rs1_value = rand64();
    return r;
  endfunction

  function automatic logic [31:0] exact_word();
    case ($urandom_range(0, 6))
      0: return W_ECALL;
      1: return W_EBREAK;
      2: return W_SRET;
      3: return W_MRET;
      4: return W_WFI;
      5: return W_WRS_NTO;
      default: return W_WRS_STO;
    endcase
  endfunction

  function automatic logic [2:0] csr_funct3();
    case ($urandom_range(0, 5))
      0: return F3_CSRRW;
      1: return F3_CSRRS;
      2: return F3_CSRRC;
      3: return F3_CSRRWI;
      4: return F3_CSRRSI;
      default: return F3_CSRRCI;
    endcase
  endfunction

  // Mostly well-formed SYSTEM words with random content, plus noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0, 1: w = exact_word();
      2, 3: begin
        w = {F7_SFENCE, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), F3_PRIV,
             5'd0, OP_SYSTEM};
        if ($urandom_range(0, 5) == 0) w[11:7] = 5'($urandom_range(1, 31));
      end
      4, 5, 6: w = {12'($urandom_range(0, 4095)), 5'($urandom_range(0, 31)), csr_funct3(),
                    5'($urandom_range(0, 31)), OP_SYSTEM};
      7: begin
        w = {w[31:15], F3_MOP, w[11:7], OP_SYSTEM};
        if ($urandom_range(0, 1)) w = (w & ~MOP_MASK) | MOP_MATCH;
      end
      8: w = exact_word() ^ (32'd1 << $urandom_range(0, 31));
      default: if ($urandom_range(0, 1)) w[6:0] = OP_SYSTEM;
    endcase
    return w;
  endfunction

  // Present one item in bursts with random gaps; hold until accepted
  task automatic issue(request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    sb.note_item(r);
  endtask

  task automatic run_directed();
    logic [63:0] st;
    st = rand64();
    // ecall from every privilege, including the reserved one
    issue(make_item(W_ECALL, PRIV_U, st));
    issue(make_item(W_ECALL, PRIV_S, st));
    issue(make_item(W_ECALL, PRIV_RSVD, st));
    issue(make_item(W_ECALL, PRIV_M, st));
    issue(make_item(W_EBREAK, PRIV_U, '1));
    // sret: user is refused, TSR blocks supervisor, machine ignores TSR
    issue(make_item(W_SRET, PRIV_U, st & ~(64'd1 << B_TSR)));
    issue(make_item(W_SRET, PRIV_S, st | (64'd1 << B_TSR)));
    issue(make_item(W_SRET, PRIV_S, '0));
    issue(make_item(W_SRET, PRIV_M, '1));
    // mret only in machine mode, every MPP including reserved two
    issue(make_item(W_MRET, PRIV_S, st));
    issue(make_item(W_MRET, PRIV_M, '0));
    issue(make_item(W_MRET, PRIV_M, (st & ~(64'd3 << B_MPP)) | (64'd1 << B_MPP)));
    issue(make_item(W_MRET, PRIV_M, (st & ~(64'd3 << B_MPP)) | (64'd2 << B_MPP)));
    issue(make_item(W_MRET, PRIV_M, '1));
    // wfi under TW
    issue(make_item(W_WFI, PRIV_U, '0));
    issue(make_item(W_WFI, PRIV_S, 64'd1 << B_TW));
    issue(make_item(W_WFI, PRIV_S, '0));
    issue(make_item(W_WRS_NTO, PRIV_U, st));
    issue(make_item(W_WRS_STO, PRIV_M, st));
    // sfence.vma: full flush, page flush, TVM trap from supervisor
    issue(make_item(FENCE_VMA, PRIV_S, '0));
    issue(make_item(FENCE_VMA | (32'd31 << 15), PRIV_M, '1));
    issue(make_item(FENCE_VMA | (32'd5 << 15), PRIV_S, 64'd1 << B_TVM));
    // csr forms at the field extremes, may-be-op hit and miss, stray bits
    issue(make_item({12'hFFF, 5'd0, F3_CSRRS, 5'd31, OP_SYSTEM}, PRIV_U, st));
    issue(make_item({12'h000, 5'd31, F3_CSRRCI, 5'd0, OP_SYSTEM}, PRIV_M, st));
    issue(make_item(MOP_MATCH | {17'd0, F3_MOP, 5'd0, OP_SYSTEM}, PRIV_U, st));
    issue(make_item({17'd0, F3_MOP, 5'd0, OP_SYSTEM}, PRIV_U, st));
    issue(make_item(W_ECALL | (32'd1 << 7), PRIV_M, st));
    issue(make_item('1, PRIV_M, '1));
  endtask

  // Reset, stimulus, drain and verdict
  initial begin
    sb = new();
    burst_left = 0;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      issue(make_item(random_word(), 2'($urandom_range(0, 3)), rand64()));
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("privileged_system_insn_decoder_top regression: pass");
    end else begin
      $display("privileged_system_insn_decoder_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("privileged_system_insn_decoder_top regression: fail");
    $finish;
  end

endmodule

[privileged_system_insn_decoder_top.f]
hw/rtl/psid_pkg.sv
hw/rtl/privileged_system_insn_decoder_top.sv
bench/tb_privileged_system_insn_decoder_top.sv
